// File: hw/rtl/sssr_pkg.sv
// Shared types, register indexes and constants for the scan spot to source ray core.
// Used by the cell modules, the top level and the port checker; no dependencies.

package sssr_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 32;
	localparam int SAD_W      = 20;

	localparam logic [CFG_IDX_W-1:0] CFG_SAD_X    = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SAD_Y    = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SRC_DIST = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BEAM_Y   = 4'd3;

	localparam logic [SAD_W-1:0] SAD_RST = 20'd128000;

	// result error codes
	localparam logic [1:0] ERR_OK  = 2'd0;
	localparam logic [1:0] ERR_SAD = 2'd1;
	localparam logic [1:0] ERR_SRC = 2'd2;

	// cycles from an accepted item to its result strobe being sampled
	localparam int OUT_LAT = 59;

	// restoring divider cell: remainder, numerator bits still to shift in, divisor, quotient
	typedef struct packed {
		logic [33:0] rem;
		logic [21:0] num;
		logic [33:0] den;
		logic [21:0] quo;
	} div_t;

	// square root cell: radicand remainder and partial root
	typedef struct packed {
		logic [63:0] rad;
		logic [63:0] root;
	} sq_t;

	// vectoring CORDIC cell
	typedef struct packed {
		logic signed [32:0] x;
		logic signed [32:0] y;
		logic signed [26:0] z;
	} cr_t;

	// atan(2^-i) in Q24
	localparam logic [26:0] ATAN_Q24 [24] = '{
		27'd13176795, 27'd7778716, 27'd4110060, 27'd2086331, 27'd1047214, 27'd524117,
		27'd262123, 27'd131069, 27'd65536, 27'd32768, 27'd16384, 27'd8192,
		27'd4096, 27'd2048, 27'd1024, 27'd512, 27'd256, 27'd128,
		27'd64, 27'd32, 27'd16, 27'd8, 27'd4, 27'd2
	};

	function automatic logic signed [26:0] atan_q24(input logic [4:0] step);
		logic signed [26:0] a;
		a = '0;
		if (step < 5'd24) begin
			a = $signed(ATAN_Q24[step]);
		end
		return a;
	endfunction

endpackage

// File: hw/rtl/sssr_div_cell.sv
// One step of a restoring divider, registered.
// Depends on sssr_pkg (div_t).

module sssr_div_cell import sssr_pkg::*; (
	input  logic clk,
	input  div_t op,
	output div_t res
);

	logic [33:0] trial;
	logic        ge;

	// shift in the next numerator bit and try the divisor
	always_comb begin
		trial = {op.rem[32:0], op.num[21]};
		ge    = trial >= op.den;
	end

	always_ff @(posedge clk) begin
		res.rem <= ge ? trial - op.den : trial;
		res.num <= {op.num[20:0], 1'b0};
		res.den <= op.den;
		res.quo <= {op.quo[20:0], ge};
	end

endmodule

// File: hw/rtl/sssr_sqrt_cell.sv
// One step of a bit-by-bit integer square root, registered.
// Depends on sssr_pkg (sq_t).

module sssr_sqrt_cell import sssr_pkg::*; (
	input  logic       clk,
	input  logic [4:0] step,
	input  sq_t        op,
	output sq_t        res
);

	logic [63:0] bitv;
	logic [63:0] trial;

	always_comb begin
		bitv  = 64'd1 << (6'd62 - {step, 1'b0});
		trial = op.root + bitv;
	end

	// take the bit where the remainder allows it
	always_ff @(posedge clk) begin
		if (op.rad >= trial) begin
			res.rad  <= op.rad - trial;
			res.root <= (op.root >> 1) + bitv;
		end else begin
			res.rad  <= op.rad;
			res.root <= op.root >> 1;
		end
	end

endmodule

// File: hw/rtl/sssr_cordic_cell.sv
// One vectoring CORDIC rotation, registered; holds once y has reached zero.
// Depends on sssr_pkg (cr_t, atan_q24).

module sssr_cordic_cell import sssr_pkg::*; (
	input  logic       clk,
	input  logic [4:0] step,
	input  cr_t        op,
	output cr_t        res
);

	logic signed [32:0] xs;
	logic signed [32:0] ys;
	logic signed [26:0] ang;

	always_comb begin
		xs  = op.x >>> step;
		ys  = op.y >>> step;
		ang = atan_q24(step);
	end

	// rotate towards y = 0
	always_ff @(posedge clk) begin
		if (op.y == '0) begin
			res <= op;
		end else if (!op.y[32]) begin
			res.x <= op.x + ys;
			res.y <= op.y - xs;
			res.z <= op.z + ang;
		end else begin
			res.x <= op.x - ys;
			res.y <= op.y + xs;
			res.z <= op.z - ang;
		end
	end

endmodule

// File: hw/rtl/scan_spot_to_source_ray_core.sv
// Scan spot to virtual source ray: source point, unit direction and deflection angles.
// Depends on sssr_pkg and the divider, square root and CORDIC cells.
//
//  channel  | signals                                  | handshake
//  ---------+------------------------------------------+------------------------------
//  item in  | start, busy, spot_x, spot_y              | taken when start & !busy
//  config   | cfg_valid, cfg_ready, cfg_index, cfg_data| written when valid & ready
//  result   | done, err_code, src_*, dir_*, angle_*    | one cycle strobe, no back-pressure
//
// A pipeline of 59 stages: one item a cycle while busy is low; the strobe leaves the last stage.
// Depth is set by the 32 square root cells followed by the 16 divider cells of the direction.
// busy is set in reset and clears on the clock after it; configuration is always accepted.
// The result side cannot stall, so nothing in the pipeline ever holds.

module scan_spot_to_source_ray_core import sssr_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic signed [15:0]     spot_x,
	input  logic signed [15:0]     spot_y,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output logic                   done,
	output logic [1:0]             err_code,
	output logic signed [20:0]     src_x,
	output logic signed [20:0]     src_y,
	output logic signed [20:0]     src_z,
	output logic signed [15:0]     dir_x,
	output logic signed [15:0]     dir_y,
	output logic signed [15:0]     dir_z,
	output logic signed [16:0]     angle_x,
	output logic signed [16:0]     angle_y
);

	localparam int LAST = 58;

	function automatic logic [15:0] abs16(input logic signed [15:0] s);
		logic [15:0] m;
		m = s[15] ? (~s + 16'd1) : s;
		return m;
	endfunction

	function automatic logic [20:0] src_fmt(input logic [21:0] q, input logic ovf,
			input logic neg);
		logic [20:0] r;
		if (!neg) begin
			r = (ovf || q > 22'd1048575) ? 21'h0FFFFF : q[20:0];
		end else begin
			r = (ovf || q > 22'd1048576) ? 21'h100000 : 21'(22'd0 - q);
		end
		return r;
	endfunction

	function automatic logic [15:0] dir_fmt(input logic [21:0] quo, input logic neg);
		logic [15:0] r;
		logic [15:0] d;
		r = quo[15:0];
		if (neg) begin
			d = 16'd0 - r;
		end else begin
			d = r[15] ? 16'h7FFF : r;
		end
		return d;
	endfunction

	function automatic logic [16:0] ang_fmt(input logic signed [26:0] z, input logic neg);
		logic signed [26:0] t;
		logic [16:0]        r;
		t = (z + 27'sd256) >>> 9;
		r = t[26] ? 17'd0 : t[16:0];
		return neg ? 17'd0 - r : r;
	endfunction

	logic [SAD_W-1:0] sad_x_q, sad_y_q, sd_q;
	logic             beam_y_q;
	logic             busy_q;
	logic             accept;
	logic [LAST:1]    vld_s;

	logic signed [15:0] sx_s [1:LAST];
	logic signed [15:0] sy_s [1:LAST];

	logic [39:0] nu_s [1:7];
	logic [39:0] nv_s [1:7];
	logic [39:0] nw_s [1:7];
	logic [30:0] cu_s [8:41];
	logic [30:0] cv_s [8:41];
	logic [30:0] cw_s [8:41];
	logic [61:0] squ_s8, sqv_s8, sqw_s8;
	sq_t         sq_s [9:41];
	logic [31:0] qroot;
	div_t        du_s [42:LAST];
	div_t        dv_s [42:LAST];
	div_t        dw_s [42:LAST];

	logic signed [20:0] dfx, dfy;
	logic signed [36:0] nmx_s35, nmy_s35;
	logic [35:0]        magx, magy;
	logic [36:0]        nx, ny;
	div_t               dsx_s [36:LAST];
	div_t               dsy_s [36:LAST];
	logic               ovfx_s [36:LAST];
	logic               ovfy_s [36:LAST];

	cr_t cax_s [29:LAST];
	cr_t cay_s [29:LAST];

	assign accept    = start && !busy_q;
	assign busy      = busy_q;
	assign cfg_ready = 1'b1;

	// control: configuration, valid line, strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sad_x_q  <= SAD_RST;
			sad_y_q  <= SAD_RST;
			sd_q     <= SAD_RST;
			beam_y_q <= 1'b0;
			busy_q   <= 1'b1;
			vld_s    <= '0;
			done     <= 1'b0;
		end else begin
			busy_q <= 1'b0;
			vld_s  <= {vld_s[LAST-1:1], accept};
			done   <= vld_s[LAST];
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_SAD_X:    sad_x_q  <= cfg_data[SAD_W-1:0];
					CFG_SAD_Y:    sad_y_q  <= cfg_data[SAD_W-1:0];
					CFG_SRC_DIST: sd_q     <= cfg_data[SAD_W-1:0];
					CFG_BEAM_Y:   beam_y_q <= cfg_data[0];
					default: ;
				endcase
			end
		end
	end

	// spot positions travel alongside for signs and late taps
	always_ff @(posedge clk) begin
		sx_s[1] <= spot_x;
		sy_s[1] <= spot_y;
		for (int k = 2; k <= LAST; k++) begin
			sx_s[k] <= sx_s[k-1];
			sy_s[k] <= sy_s[k-1];
		end
	end

	// direction: scaled magnitudes
	always_ff @(posedge clk) begin
		nu_s[1] <= 40'(abs16(spot_x)) * 40'(sad_y_q);
		nv_s[1] <= 40'(abs16(spot_y)) * 40'(sad_x_q);
		nw_s[1] <= 40'(sad_x_q) * 40'(sad_y_q);
	end

	// direction: bring the largest magnitude to the top bit, one shift size a stage
	for (genvar g = 0; g < 6; g++) begin : g_dnrm
		localparam int SH = 32 >> g;
		logic lead0;
		assign lead0 = ((nu_s[g+1] | nv_s[g+1] | nw_s[g+1]) >> (40 - SH)) == 40'd0;
		always_ff @(posedge clk) begin
			if (lead0) begin
				nu_s[g+2] <= nu_s[g+1] << SH;
				nv_s[g+2] <= nv_s[g+1] << SH;
				nw_s[g+2] <= nw_s[g+1] << SH;
			end else begin
				nu_s[g+2] <= nu_s[g+1];
				nv_s[g+2] <= nv_s[g+1];
				nw_s[g+2] <= nw_s[g+1];
			end
		end
	end

	// direction: squares, sum, and the components held for the division
	always_ff @(posedge clk) begin
		cu_s[8] <= nu_s[7][39:9];
		cv_s[8] <= nv_s[7][39:9];
		cw_s[8] <= nw_s[7][39:9];
		squ_s8  <= 62'(nu_s[7][39:9]) * 62'(nu_s[7][39:9]);
		sqv_s8  <= 62'(nv_s[7][39:9]) * 62'(nv_s[7][39:9]);
		sqw_s8  <= 62'(nw_s[7][39:9]) * 62'(nw_s[7][39:9]);
		sq_s[9] <= '{rad: 64'(squ_s8) + 64'(sqv_s8) + 64'(sqw_s8), root: 64'd0};
		for (int k = 9; k <= 41; k++) begin
			cu_s[k] <= cu_s[k-1];
			cv_s[k] <= cv_s[k-1];
			cw_s[k] <= cw_s[k-1];
		end
	end

	for (genvar j = 0; j < 32; j++) begin : g_sqrt
		sssr_sqrt_cell u_sqrt (.clk(clk), .step(5'(j)), .op(sq_s[9+j]), .res(sq_s[10+j]));
	end

	assign qroot = sq_s[41].root[31:0];

	// direction: load the dividers, c*2^16 + q over 2q
	always_ff @(posedge clk) begin
		du_s[42] <= '{rem: 34'(cu_s[41]) + 34'(qroot[31:16]), num: {qroot[15:0], 6'd0},
			den: {1'b0, qroot, 1'b0}, quo: 22'd0};
		dv_s[42] <= '{rem: 34'(cv_s[41]) + 34'(qroot[31:16]), num: {qroot[15:0], 6'd0},
			den: {1'b0, qroot, 1'b0}, quo: 22'd0};
		dw_s[42] <= '{rem: 34'(cw_s[41]) + 34'(qroot[31:16]), num: {qroot[15:0], 6'd0},
			den: {1'b0, qroot, 1'b0}, quo: 22'd0};
	end

	for (genvar j = 0; j < 16; j++) begin : g_ddiv
		sssr_div_cell u_du (.clk(clk), .op(du_s[42+j]), .res(du_s[43+j]));
		sssr_div_cell u_dv (.clk(clk), .op(dv_s[42+j]), .res(dv_s[43+j]));
		sssr_div_cell u_dw (.clk(clk), .op(dw_s[42+j]), .res(dw_s[43+j]));
	end

	// source point: spot * (sad - distance), rounded over sad
	always_comb begin
		dfx  = $signed({1'b0, sad_x_q}) - $signed({1'b0, sd_q});
		dfy  = $signed({1'b0, sad_y_q}) - $signed({1'b0, sd_q});
		magx = nmx_s35[36] ? 36'(-nmx_s35) : 36'(nmx_s35);
		magy = nmy_s35[36] ? 36'(-nmy_s35) : 36'(nmy_s35);
		nx   = {magx, 1'b0} + 37'(sad_x_q);
		ny   = {magy, 1'b0} + 37'(sad_y_q);
	end

	always_ff @(posedge clk) begin
		nmx_s35    <= 37'(sx_s[34]) * 37'(dfx);
		nmy_s35    <= 37'(sy_s[34]) * 37'(dfy);
		dsx_s[36]  <= '{rem: 34'(nx[36:22]), num: nx[21:0], den: 34'({sad_x_q, 1'b0}),
			quo: 22'd0};
		dsy_s[36]  <= '{rem: 34'(ny[36:22]), num: ny[21:0], den: 34'({sad_y_q, 1'b0}),
			quo: 22'd0};
		ovfx_s[36] <= {6'd0, nx[36:22]} >= {sad_x_q, 1'b0};
		ovfy_s[36] <= {6'd0, ny[36:22]} >= {sad_y_q, 1'b0};
		for (int k = 37; k <= LAST; k++) begin
			ovfx_s[k] <= ovfx_s[k-1];
			ovfy_s[k] <= ovfy_s[k-1];
		end
	end

	for (genvar j = 0; j < 22; j++) begin : g_sdiv
		sssr_div_cell u_sx (.clk(clk), .op(dsx_s[36+j]), .res(dsx_s[37+j]));
		sssr_div_cell u_sy (.clk(clk), .op(dsy_s[36+j]), .res(dsy_s[37+j]));
	end

	// angles: start vectors from the distance and the spot magnitude
	always_comb begin
		cax_s[29] = '{x: 33'(sad_x_q), y: 33'(abs16(sx_s[29])), z: 27'sd0};
		cay_s[29] = '{x: 33'(sad_y_q), y: 33'(abs16(sy_s[29])), z: 27'sd0};
	end

	// angles: scale both up together until one reaches 2^28
	for (genvar g = 0; g < 5; g++) begin : g_anrm
		localparam int SH = 16 >> g;
		logic lead_x, lead_y;
		assign lead_x = ((cax_s[29+g].x | cax_s[29+g].y) >> (29 - SH)) == 33'd0;
		assign lead_y = ((cay_s[29+g].x | cay_s[29+g].y) >> (29 - SH)) == 33'd0;
		always_ff @(posedge clk) begin
			cax_s[30+g] <= lead_x ? cr_t'{x: cax_s[29+g].x <<< SH, y: cax_s[29+g].y <<< SH,
				z: 27'sd0} : cax_s[29+g];
			cay_s[30+g] <= lead_y ? cr_t'{x: cay_s[29+g].x <<< SH, y: cay_s[29+g].y <<< SH,
				z: 27'sd0} : cay_s[29+g];
		end
	end

	for (genvar j = 0; j < 24; j++) begin : g_cordic
		sssr_cordic_cell u_cx (.clk(clk), .step(5'(j)), .op(cax_s[34+j]), .res(cax_s[35+j]));
		sssr_cordic_cell u_cy (.clk(clk), .step(5'(j)), .op(cay_s[34+j]), .res(cay_s[35+j]));
	end

	// result register: format, map axes, zero on a bad configuration
	always_ff @(posedge clk) begin
		if (sad_x_q == '0 || sad_y_q == '0 || sd_q == '0) begin
			err_code <= (sad_x_q == '0 || sad_y_q == '0) ? ERR_SAD : ERR_SRC;
			src_x    <= '0;
			src_y    <= '0;
			src_z    <= '0;
			dir_x    <= '0;
			dir_y    <= '0;
			dir_z    <= '0;
			angle_x  <= '0;
			angle_y  <= '0;
		end else begin
			err_code <= ERR_OK;
			src_x    <= src_fmt(dsx_s[LAST].quo, ovfx_s[LAST], sx_s[LAST][15] ^ (sad_x_q < sd_q));
			dir_x    <= dir_fmt(du_s[LAST].quo, sx_s[LAST][15]);
			angle_x  <= ang_fmt(cax_s[LAST].z, sx_s[LAST][15]);
			angle_y  <= ang_fmt(cay_s[LAST].z, sy_s[LAST][15]);
			if (beam_y_q) begin
				src_y <= 21'd0 - {1'b0, sd_q};
				src_z <= src_fmt(dsy_s[LAST].quo, ovfy_s[LAST], sy_s[LAST][15] ^ (sad_y_q < sd_q));
				dir_y <= dir_fmt(dw_s[LAST].quo, 1'b0);
				dir_z <= dir_fmt(dv_s[LAST].quo, sy_s[LAST][15]);
			end else begin
				src_y <= src_fmt(dsy_s[LAST].quo, ovfy_s[LAST], sy_s[LAST][15] ^ (sad_y_q < sd_q));
				src_z <= 21'd0 - {1'b0, sd_q};
				dir_y <= dir_fmt(dv_s[LAST].quo, sy_s[LAST][15]);
				dir_z <= dir_fmt(dw_s[LAST].quo, 1'b0);
			end
		end
	end

endmodule

// File: hw/rtl/sssr_chk.sv
// Port-level checker for scan_spot_to_source_ray_core, bound to the top level.
// Depends on sssr_pkg (error codes, latency).

module sssr_chk import sssr_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  start,
	input logic                  busy,
	input logic signed [15:0]    spot_x,
	input logic signed [15:0]    spot_y,
	input logic                  cfg_valid,
	input logic                  cfg_ready,
	input logic [CFG_IDX_W-1:0]  cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data,
	input logic                  done,
	input logic [1:0]            err_code,
	input logic signed [20:0]    src_x,
	input logic signed [20:0]    src_y,
	input logic signed [20:0]    src_z,
	input logic signed [15:0]    dir_x,
	input logic signed [15:0]    dir_y,
	input logic signed [15:0]    dir_z,
	input logic signed [16:0]    angle_x,
	input logic signed [16:0]    angle_y
);

	// every accepted item yields its result after the fixed latency
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##OUT_LAT done)
		else $error("accepted item produced no result");

	// no result without an item accepted the latency before
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, OUT_LAT))
		else $error("result without a matching item");

	a_err_legal: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (err_code == ERR_OK || err_code == ERR_SAD || err_code == ERR_SRC))
		else $error("undefined error code");

	// an error result carries nothing else
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && err_code != ERR_OK) |-> (src_x == 0 && src_y == 0 && src_z == 0 &&
		dir_x == 0 && dir_y == 0 && dir_z == 0 && angle_x == 0 && angle_y == 0))
		else $error("error result with nonzero fields");

endmodule

bind scan_spot_to_source_ray_core sssr_chk u_sssr_chk (.*);
